@@ design/aip_pkg.sv @@
// ----------------------------------------------------------------------------
// aip_pkg
// Shared types and character constants for the ascii integer parser.
// ----------------------------------------------------------------------------
package aip_pkg;

    // character codes
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CH_UC_X  = 8'h58;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    // letter digits start at ten
    localparam logic [7:0] LETTER_BIAS = 8'd10;

    // configuration register indexes
    localparam logic [1:0] CFG_HEX_MODE     = 2'd0;
    localparam logic [1:0] CFG_SIGNED_MODE  = 2'd1;
    localparam logic [1:0] CFG_RESULT_WIDTH = 2'd2;

    // result width codes
    localparam logic [1:0] RW_8  = 2'd0;
    localparam logic [1:0] RW_16 = 2'd1;
    localparam logic [1:0] RW_32 = 2'd2;
    localparam logic [1:0] RW_64 = 2'd3;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [63:0] value;
        logic        status;
    } out_word_t;

    typedef struct packed {
        logic       hex_mode;
        logic       signed_mode;
        logic [1:0] result_width;
    } cfg_t;

    // classified byte as it travels through the queue
    typedef struct packed {
        logic [3:0] digit;
        logic       is_dec;
        logic       is_hex;
        logic       is_plus;
        logic       is_minus;
        logic       is_x;
        logic       last;
    } cls_t;

    // finished string handed to the output formatter
    typedef struct packed {
        logic [63:0] acc;
        logic        negative;
        logic        error;
        logic        signed_mode;
        logic [1:0]  result_width;
    } fin_t;

    typedef enum logic [1:0] {
        PH_START,
        PH_AFTER_SIGN,
        PH_HELD,
        PH_DIGITS
    } phase_t;

endpackage

@@ design/aip_front.sv @@
// ----------------------------------------------------------------------------
// aip_front
// Accepts input words and classifies each character for the parser.
// ----------------------------------------------------------------------------
module aip_front
    import aip_pkg::*;
(
    input  logic     in_valid,
    output logic     in_ready,
    input  in_word_t in_data,
    input  logic     q_full,
    output logic     q_push,
    output cls_t     q_data
);

    logic [7:0] c;
    logic [7:0] dig8;

    assign c        = in_data.char_byte;
    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

    always_comb
    begin
        q_data       = '0;
        dig8         = 8'd0;
        q_data.last  = in_data.last_byte;
        q_data.is_plus  = (c == CH_PLUS);
        q_data.is_minus = (c == CH_MINUS);
        q_data.is_x     = (c == CH_LC_X) || (c == CH_UC_X);
        if (c inside {[CH_0:CH_9]})
        begin
            dig8          = c - CH_0;
            q_data.is_dec = 1'b1;
            q_data.is_hex = 1'b1;
        end
        else if (c inside {[CH_LC_A:CH_LC_F]})
        begin
            dig8          = c - CH_LC_A + LETTER_BIAS;
            q_data.is_hex = 1'b1;
        end
        else if (c inside {[CH_UC_A:CH_UC_F]})
        begin
            dig8          = c - CH_UC_A + LETTER_BIAS;
            q_data.is_hex = 1'b1;
        end
        q_data.digit = dig8[3:0];
    end

endmodule

@@ design/aip_queue.sv @@
// ----------------------------------------------------------------------------
// aip_queue
// Short queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module aip_queue
    import aip_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cls_t push_data,
    output logic full,
    input  logic pop,
    output logic empty,
    output cls_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cls_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ design/aip_back.sv @@
// ----------------------------------------------------------------------------
// aip_back
// Parse sequencer: sign, prefix and digit accumulation, one character a cycle unless a result is stalled.
// ----------------------------------------------------------------------------
module aip_back
    import aip_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic q_empty,
    input  cls_t q_head,
    output logic q_pop,
    output logic fin_valid,
    input  logic fin_ready,
    output fin_t fin_data
);

    phase_t      phase_reg, phase_next;
    logic [63:0] acc_reg, acc_next, acc_upd;
    logic        neg_reg, neg_next, neg_upd;
    logic        err_reg, err_next, err_upd;
    cls_t        held_reg, held_next;
    logic        fin_valid_reg, fin_valid_next;
    fin_t        fin_reg, fin_next;

    logic        fin_free;
    logic        e_ok, h_ok, sign_hit, hex;
    logic [63:0] operand, scaled, sum;

    assign hex      = cfg.hex_mode;
    assign fin_free = !fin_valid_reg || fin_ready;
    assign q_pop    = !q_empty && (!q_head.last || fin_free);
    assign e_ok     = hex ? q_head.is_hex : q_head.is_dec;
    assign h_ok     = hex ? held_reg.is_hex : held_reg.is_dec;
    assign sign_hit = q_head.is_plus || (cfg.signed_mode && q_head.is_minus);

    // the accumulator is still zero while a character is held
    assign operand = (phase_reg == PH_HELD) ? {60'd0, held_reg.digit} : acc_reg;
    assign scaled  = hex ? (operand << 4) : ((operand << 3) + (operand << 1));
    assign sum     = scaled + {60'd0, q_head.digit};

    assign fin_valid = fin_valid_reg;
    assign fin_data  = fin_reg;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (q_pop && !err_reg)
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (sign_hit)
                    begin
                        phase_next = q_head.last ? PH_START : PH_AFTER_SIGN;
                    end
                    else
                    begin
                        phase_next = (hex && !q_head.last) ? PH_HELD : PH_DIGITS;
                    end
                end
                PH_AFTER_SIGN:
                begin
                    phase_next = (hex && !q_head.last) ? PH_HELD : PH_DIGITS;
                end
                PH_HELD:   phase_next = PH_DIGITS;
                PH_DIGITS: phase_next = PH_DIGITS;
                default:   phase_next = PH_START;
            endcase
        end
        if (q_pop && q_head.last)
        begin
            phase_next = PH_START;
        end
    end

    // datapath updates
    always_comb
    begin
        acc_upd   = acc_reg;
        neg_upd   = neg_reg;
        err_upd   = err_reg;
        held_next = held_reg;
        if (q_pop && !err_reg)
        begin
            case (phase_reg)
                PH_START, PH_AFTER_SIGN:
                begin
                    if (phase_reg == PH_START && sign_hit)
                    begin
                        neg_upd = q_head.is_minus;
                        // lone sign
                        if (q_head.last)
                        begin
                            err_upd = 1'b1;
                        end
                    end
                    else if (hex && !q_head.last)
                    begin
                        held_next = q_head;
                    end
                    else if (!e_ok)
                    begin
                        err_upd = 1'b1;
                    end
                    else
                    begin
                        acc_upd = sum;
                    end
                end
                PH_HELD:
                begin
                    if (q_head.is_x)
                    begin
                        // bare prefix
                        if (q_head.last)
                        begin
                            err_upd = 1'b1;
                        end
                    end
                    else if (!h_ok)
                    begin
                        err_upd = 1'b1;
                    end
                    else if (!e_ok)
                    begin
                        acc_upd = {60'd0, held_reg.digit};
                        err_upd = 1'b1;
                    end
                    else
                    begin
                        acc_upd = sum;
                    end
                end
                PH_DIGITS:
                begin
                    if (!e_ok)
                    begin
                        err_upd = 1'b1;
                    end
                    else
                    begin
                        acc_upd = sum;
                    end
                end
                default:
                begin
                    err_upd = err_reg;
                end
            endcase
        end

        acc_next = acc_upd;
        neg_next = neg_upd;
        err_next = err_upd;
        fin_next = fin_reg;
        if (fin_free)
        begin
            fin_next.acc          = acc_upd;
            fin_next.negative     = neg_upd;
            fin_next.error        = err_upd;
            fin_next.signed_mode  = cfg.signed_mode;
            fin_next.result_width = cfg.result_width;
        end
        if (q_pop && q_head.last)
        begin
            acc_next = '0;
            neg_next = 1'b0;
            err_next = 1'b0;
        end
        fin_valid_next = (fin_valid_reg && !fin_ready) || (q_pop && q_head.last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            err_reg       <= 1'b0;
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            err_reg       <= err_next;
            fin_valid_reg <= fin_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
        fin_reg  <= fin_next;
    end

endmodule

@@ design/aip_format.sv @@
// ----------------------------------------------------------------------------
// aip_format
// Applies negation and result width, holds the result word for the consumer.
// ----------------------------------------------------------------------------
module aip_format
    import aip_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fin_valid,
    output logic      fin_ready,
    input  fin_t      fin_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    logic      out_valid_reg, out_valid_next;
    out_word_t out_reg, out_next;
    logic [63:0] v;
    logic        sx;

    assign fin_ready = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        // negation is dropped on an invalid string
        v  = (fin_data.negative && !fin_data.error) ? (64'd0 - fin_data.acc) : fin_data.acc;
        sx = 1'b0;
        out_next = out_reg;
        if (fin_valid && fin_ready)
        begin
            out_next.status = fin_data.error;
            case (fin_data.result_width)
                RW_8:
                begin
                    sx = fin_data.signed_mode && v[7];
                    out_next.value = {{56{sx}}, v[7:0]};
                end
                RW_16:
                begin
                    sx = fin_data.signed_mode && v[15];
                    out_next.value = {{48{sx}}, v[15:0]};
                end
                RW_32:
                begin
                    sx = fin_data.signed_mode && v[31];
                    out_next.value = {{32{sx}}, v[31:0]};
                end
                RW_64:   out_next.value = v;
                default: out_next.value = v;
            endcase
        end
        out_valid_next = (out_valid_reg && !out_ready) || fin_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

@@ design/ascii_integer_parser.sv @@
// ----------------------------------------------------------------------------
// ascii_integer_parser
// Decimal or hex ASCII string to integer, one character word per cycle when not stalled.
// ----------------------------------------------------------------------------
// usage: send the characters of one number as input words, the final one with
// last_byte set; exactly one result word comes back for that final character.
// the block sustains one character per clock while no result stalls: the
// parse sequencer folds one character a cycle into a 64-bit accumulator
// with a shift-and-add by 10 or 16, and that step sets the rate. a result
// is registered in the sequencer step, then in the formatter register,
// before it shows on out_valid. QUEUE_DEPTH words of queue sit
// between the classifier and the sequencer, so a stalled result only stops
// the input once the queue has filled. configuration (hex_mode, signed_mode,
// result_width) is written through the cfg port, always ready, and should
// only be changed between strings. no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module ascii_integer_parser
    import aip_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    // character words in
    input  logic       in_valid,
    output logic       in_ready,
    input  in_word_t   in_data,
    // result words out
    output logic       out_valid,
    input  logic       out_ready,
    output out_word_t  out_data,
    // configuration writes
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;

    // front to queue
    logic q_full;
    logic q_push;
    cls_t q_push_data;

    // queue to back
    logic q_empty;
    logic q_pop;
    cls_t q_head;

    // back to formatter
    logic fin_valid;
    logic fin_ready;
    fin_t fin_data;

    // register file, writes never stall
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HEX_MODE:     cfg_next.hex_mode     = cfg_data[0];
                CFG_SIGNED_MODE:  cfg_next.signed_mode  = cfg_data[0];
                CFG_RESULT_WIDTH: cfg_next.result_width = cfg_data[1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hex_mode     <= 1'b0;
            cfg_reg.signed_mode  <= 1'b0;
            cfg_reg.result_width <= RW_64;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // classify each character as it is accepted
    aip_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_push_data)
    );

    // decouples the classifier from the sequencer
    aip_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    // sign, prefix and digit sequencer
    aip_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin_data  (fin_data)
    );

    // negate, cut to width and hold the result word
    aip_format u_format (
        .clk       (clk),
        .rst_n     (rst_n),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin_data  (fin_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ design/aip_checker.sv @@
// ----------------------------------------------------------------------------
// aip_checker
// Port-level checks for the ascii integer parser, bound to the top level.
// ----------------------------------------------------------------------------
module aip_checker
    import aip_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input in_word_t   in_data,
    input logic       out_valid,
    input logic       out_ready,
    input out_word_t  out_data,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // a waiting character word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("character word changed while waiting");

    // the queue only fills through an accepted word
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid && in_ready))
        else $error("input stalled without a word entering the queue");

    // register writes are never held off, even mid-string
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && in_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind ascii_integer_parser aip_checker u_aip_checker (.*);

@@ test/aip_result_checker.sv @@
// ----------------------------------------------------------------------------
// aip_result_checker
// Watches the parser's character, result and configuration channels, predicts
// the result word of every string and compares it field by field.
// ----------------------------------------------------------------------------
module aip_result_checker
    import aip_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  in_word_t   in_data,
    input  logic       out_valid,
    input  logic       out_ready,
    input  out_word_t  out_data,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output int         mismatches,
    output int         pending
);

    localparam int   MAX_SHOWN    = 10;
    localparam cfg_t CFG_AT_RESET = '{hex_mode: 1'b0, signed_mode: 1'b0, result_width: RW_64};

    cfg_t        cfg_r      = CFG_AT_RESET;
    logic [63:0] acc_r      = '0;
    logic [7:0]  held_r     = '0;
    phase_t      ph_r       = PH_START;
    logic        neg_r      = 1'b0;
    logic        err_r      = 1'b0;
    int          mismatch_r = 0;
    int          pending_r  = 0;
    out_word_t   expected_results[$];

    assign mismatches = mismatch_r;
    assign pending    = pending_r;

    task automatic clear_string();
        acc_r  = '0;
        held_r = '0;
        ph_r   = PH_START;
        neg_r  = 1'b0;
        err_r  = 1'b0;
    endtask

    // digit value in the current base, -1 when not a digit
    function automatic int digit_of(input logic [7:0] c, input logic hex);
        if (c >= CH_0 && c <= CH_9)
            return int'(c - CH_0);
        if (hex && c >= CH_LC_A && c <= CH_LC_F)
            return int'(c - CH_LC_A) + int'(LETTER_BIAS);
        if (hex && c >= CH_UC_A && c <= CH_UC_F)
            return int'(c - CH_UC_A) + int'(LETTER_BIAS);
        return -1;
    endfunction

    task automatic fold_digit(input logic [7:0] c, input logic hex);
        int d;
        if (!err_r)
        begin
            d = digit_of(c, hex);
            if (d < 0)
                err_r = 1'b1;
            else
                acc_r = acc_r * (hex ? 64'd16 : 64'd10) + 64'(d);
        end
    endtask

    // first character after an optional sign; hex keeps it for the prefix test
    task automatic first_char(input logic [7:0] c, input logic last, input logic hex);
        if (hex && !last)
        begin
            held_r = c;
            ph_r   = PH_HELD;
        end
        else
        begin
            fold_digit(c, hex);
            ph_r = PH_DIGITS;
        end
    endtask

    task automatic take_char(input in_word_t w);
        logic [7:0]  c;
        logic        last;
        logic        hex;
        logic [63:0] v;
        logic [63:0] mask;
        int          bits;
        out_word_t   res;
        c    = w.char_byte;
        last = w.last_byte;
        hex  = cfg_r.hex_mode;
        if (!err_r)
        begin
            case (ph_r)
                PH_START:
                    if (c == CH_PLUS || (cfg_r.signed_mode && c == CH_MINUS))
                    begin
                        neg_r = (c == CH_MINUS);
                        if (last)
                            err_r = 1'b1;
                        else
                            ph_r = PH_AFTER_SIGN;
                    end
                    else
                        first_char(c, last, hex);
                PH_AFTER_SIGN:
                    first_char(c, last, hex);
                PH_HELD:
                begin
                    if (c == CH_LC_X || c == CH_UC_X)
                    begin
                        if (last)
                            err_r = 1'b1;
                    end
                    else
                    begin
                        fold_digit(held_r, hex);
                        fold_digit(c, hex);
                    end
                    ph_r = PH_DIGITS;
                end
                default:
                    fold_digit(c, hex);
            endcase
        end
        if (last)
        begin
            v = acc_r;
            if (neg_r && !err_r)
                v = -v;
            if (cfg_r.result_width != RW_64)
            begin
                bits = 8 << cfg_r.result_width;
                mask = (64'd1 << bits) - 64'd1;
                v    = v & mask;
                if (cfg_r.signed_mode && v[bits-1])
                    v = v | ~mask;
            end
            res.value  = v;
            res.status = err_r;
            expected_results.push_back(res);
            clear_string();
        end
    endtask

    task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
        mismatch_r++;
        if (mismatch_r <= MAX_SHOWN)
            $display("aip check: %s: expected %h, got %h", what, want, got);
    endtask

    task automatic check_result(input out_word_t got);
        out_word_t want;
        if (expected_results.size() == 0)
            report("result word with nothing expected", 64'd0, got.value);
        else
        begin
            want = expected_results.pop_front();
            if (got.value !== want.value)
                report("value", want.value, got.value);
            if (got.status !== want.status)
                report("status", 64'(want.status), 64'(got.status));
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            clear_string();
            cfg_r = CFG_AT_RESET;
            expected_results.delete();
        end
        else
        begin
            if (out_valid && out_ready)
                check_result(out_data);
            if (in_valid && in_ready)
                take_char(in_data);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_HEX_MODE:     cfg_r.hex_mode     = cfg_data[0];
                    CFG_SIGNED_MODE:  cfg_r.signed_mode  = cfg_data[0];
                    CFG_RESULT_WIDTH: cfg_r.result_width = cfg_data[1:0];
                    default: ;
                endcase
            end
        end
        pending_r <= expected_results.size();
    end

endmodule

@@ test/tb_ascii_integer_parser.sv @@
// ----------------------------------------------------------------------------
// tb_ascii_integer_parser
// Drives number strings into the ascii integer parser under many register
// settings, with bursty input and a stalling result side; a separate checker
// predicts each result word and counts mismatches.
// ----------------------------------------------------------------------------
module tb_ascii_integer_parser;
    import aip_pkg::*;

    // unused register slot, written now and then to show it has no effect
    localparam logic [1:0] CFG_UNUSED   = 2'd3;
    // settling margin once the last result word is back
    localparam int         DRAIN_CYCLES = 6;
    localparam int         PHASES       = 10;
    localparam int         PHASE_BYTES  = 80;

    // receiver behavior per phase
    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_LONG
    } rx_style_t;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    in_word_t   in_data   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_word_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data  = '0;

    int         mismatches;
    int         pending;

    rx_style_t  stall_style = RX_ALWAYS;
    int         ready_run   = 0;
    logic       use_gaps    = 1'b0;
    int         burst_left  = 0;
    int         phase_bytes = 0;
    logic [7:0] text_buf[$];

    ascii_integer_parser u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    aip_result_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop well past the slowest correct run
    initial
    begin
        #2000000;
        $display("tb_ascii_integer_parser: FAIL");
        $finish;
    end

    // result side: always ready, coin flip per cycle, or long runs of
    // ready and stall taking turns
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            ready_run <= 0;
        end
        else if (stall_style == RX_ALWAYS)
            out_ready <= 1'b1;
        else if (ready_run == 0)
        begin
            if (stall_style == RX_RANDOM)
                out_ready <= 1'($urandom_range(0, 1));
            else
            begin
                out_ready <= !out_ready;
                ready_run <= $urandom_range(1, 12);
            end
        end
        else
            ready_run <= ready_run - 1;
    end

    // one character word; called at a clock edge, returns at the edge that
    // takes it. between bursts, when gaps are on, the valid drops for a random gap
    task automatic send_word(input logic [7:0] c, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = use_gaps ? $urandom_range(1, 8) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid           <= 1'b1;
        in_data.char_byte  <= c;
        in_data.last_byte  <= last;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_string(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_word(s[i], i == s.len() - 1);
    endtask

    task automatic send_buf();
        int i;
        for (i = 0; i < text_buf.size(); i++)
            send_word(text_buf[i], i == text_buf.size() - 1);
        phase_bytes += text_buf.size();
    endtask

    // drop the valid, then wait until every result word is back and the
    // block has settled before touching the registers again
    task automatic finish_phase();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // all three registers back to back; upper data bits are junk on purpose
    task automatic program_config(input logic h, input logic s, input logic [1:0] w);
        write_reg(CFG_HEX_MODE, {7'($urandom_range(0, 127)), h});
        write_reg(CFG_SIGNED_MODE, {7'($urandom_range(0, 127)), s});
        write_reg(CFG_RESULT_WIDTH, {6'($urandom_range(0, 63)), w});
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_digit(input logic hex);
        int r;
        if (!hex)
            return CH_0 + 8'($urandom_range(0, 9));
        r = $urandom_range(0, 15);
        if (r < 10)
            return CH_0 + 8'(r);
        if ($urandom_range(0, 1) == 1)
            return CH_LC_A + 8'(r - 10);
        return CH_UC_A + 8'(r - 10);
    endfunction

    // mostly well-formed numbers with random content: optional sign, optional
    // prefix in hex, short digit runs and now and then a long one that can wrap
    // the accumulator; the rest is raw noise or a number with one byte spoiled
    task automatic build_string(input logic hex);
        int kind;
        int n;
        int i;
        text_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++)
                text_buf.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            case ($urandom_range(0, 5))
                0: text_buf.push_back(CH_PLUS);
                1: text_buf.push_back(CH_MINUS);
                default: ;
            endcase
            if (hex && $urandom_range(0, 2) == 0)
            begin
                // prefix lead need not be a zero
                text_buf.push_back(($urandom_range(0, 3) == 0) ? pick_digit(1'b1) : CH_0);
                text_buf.push_back(($urandom_range(0, 1) == 1) ? CH_LC_X : CH_UC_X);
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 22) : $urandom_range(0, 6);
            for (i = 0; i < n; i++)
                text_buf.push_back(pick_digit(hex));
            if (text_buf.size() == 0)
                text_buf.push_back(pick_digit(hex));
            if (kind < 20)
                text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
        end
    endtask

    initial
    begin
        int         p;
        logic       hex_sel;
        logic       sgn_sel;
        logic [1:0] width_sel;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: hex, signed, full width
        program_config(1'b1, 1'b1, RW_64);
        send_string("+");       // lone plus
        send_string("-");       // lone minus
        send_string("0x");      // bare prefix
        send_string("7");       // single hex character, no prefix test
        send_string("-1xF");    // prefix lead that is not a zero, negated
        send_string("aG");      // bad digit keeps the value before it
        send_word(8'hFF, 1'b1); // top byte value as a bad digit
        finish_phase();

        // directed: decimal, unsigned, narrowest width
        program_config(1'b0, 1'b0, RW_8);
        send_string("-5");      // minus is a bad digit when unsigned
        send_string("255");
        send_string("+9");
        send_word(8'h00, 1'b1); // zero byte
        finish_phase();

        // random phases: first four walk hex and signed, the first two with both
        // width extremes, the rest pick everything at random
        for (p = 0; p < PHASES; p++)
        begin
            hex_sel   = (p < 4) ? 1'(p) : 1'($urandom_range(0, 1));
            sgn_sel   = (p < 4) ? 1'(p >> 1) : 1'($urandom_range(0, 1));
            width_sel = (p == 0) ? RW_8 : (p == 1) ? RW_64 : 2'($urandom_range(0, 3));
            program_config(hex_sel, sgn_sel, width_sel);
            stall_style = rx_style_t'(p % 3);
            use_gaps    = (p % 4 != 0);
            burst_left  = 0;
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                build_string(hex_sel);
                send_buf();
            end
            finish_phase();
        end

        if (mismatches == 0 && pending == 0)
            $display("tb_ascii_integer_parser: PASS");
        else
            $display("tb_ascii_integer_parser: FAIL");
        $finish;
    end

endmodule
